### rtl/base64_stream_codec_core_macros.svh
// Assertion macros shared by the base64 stream codec modules.
// Each macro expects the using module to have ports named clock and reset.
`ifndef BASE64_STREAM_CODEC_CORE_MACROS_SVH
`define BASE64_STREAM_CODEC_CORE_MACROS_SVH

// Same-cycle implication, checked outside of reset.
`define B64SC_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside of reset.
`define B64SC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/b64sc_pkg.sv
// Package for the base64 stream codec: beat payload types, group job type,
// character constants and the alphabet mapping functions. No dependencies.
`timescale 1ns / 1ps

package b64sc_pkg;

   // Padding character '='.
   localparam logic [7:0] CHAR_PAD = 8'h3D;

   // Kinds of group jobs handed from the front to the back.
   localparam logic [1:0] JOB_ENCODE = 2'd0;
   localparam logic [1:0] JOB_DECODE = 2'd1;
   localparam logic [1:0] JOB_ERROR  = 2'd2;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       is_final;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_final;
      logic       bad_length;
   } rsp_payload_type;

   // One finished group: everything the back needs to emit its beats.
   typedef struct packed {
      logic [1:0]  kind;
      logic [23:0] bits;
      logic [2:0]  count;   // number of result beats, 1 to 4
      logic [2:0]  chars;   // encode only: characters before padding
      logic        fin;
   } job_type;

   // Sextet value to base64 character.
   function automatic logic [7:0] char_of(input logic [5:0] v);
      logic [7:0] w;
      w = {2'b00, v};
      if (w < 8'd26) begin
         char_of = 8'(8'h41 + w);
      end else if (w < 8'd52) begin
         char_of = 8'(8'h61 + w - 8'd26);
      end else if (w < 8'd62) begin
         char_of = 8'(8'h30 + w - 8'd52);
      end else if (w == 8'd62) begin
         char_of = 8'h2B;
      end else begin
         char_of = 8'h2F;
      end
   endfunction

   // Base64 character to sextet; anything outside the alphabet gives zero.
   function automatic logic [5:0] sextet_of(input logic [7:0] c);
      if (c >= 8'h41 && c <= 8'h5A) begin
         sextet_of = 6'(c - 8'h41);
      end else if (c >= 8'h61 && c <= 8'h7A) begin
         sextet_of = 6'(c - 8'h61 + 8'd26);
      end else if (c >= 8'h30 && c <= 8'h39) begin
         sextet_of = 6'(c - 8'h30 + 8'd52);
      end else if (c == 8'h2B) begin
         sextet_of = 6'd62;
      end else if (c == 8'h2F) begin
         sextet_of = 6'd63;
      end else begin
         sextet_of = 6'd0;
      end
   endfunction

endpackage

### rtl/b64sc_queue.sv
// Two-entry job queue between the codec front and back.
// Depends on b64sc_pkg for the job type and on the assertion macro header.
`timescale 1ns / 1ps
`include "base64_stream_codec_core_macros.svh"

module b64sc_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  b64sc_pkg::job_type push_job,
   output logic              full,
   output logic              pop_valid,
   output b64sc_pkg::job_type pop_job,
   input  logic              pop
);

   b64sc_pkg::job_type slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full      = (count_ff == 2'd2);
   assign pop_valid = (count_ff != 2'd0);
   assign pop_job   = slot_ff[rd_ptr_ff];

   // Pointer and occupancy update.
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = 2'(count_ff + {1'b0, push} - {1'b0, pop});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Slot storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

   `B64SC_ASSERT_NOW(a_no_overflow, push, !full || pop, "job pushed into a full queue")
   `B64SC_ASSERT_NOW(a_pop_has_job, pop, pop_valid, "job popped from an empty queue")
   `B64SC_ASSERT_NOW(a_count_bound, 1'b1, count_ff <= 2'd2, "queue occupancy above two")

endmodule

### rtl/b64sc_front.sv
// Codec front: holds the direction register, accepts input beats, packs them
// into groups and pushes one finished job per group. Depends on b64sc_pkg.
`timescale 1ns / 1ps

module b64sc_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_wr_en,
   input  logic                       csr_wr_data,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  b64sc_pkg::req_payload_type req_payload,
   input  logic                       queue_full,
   output logic                       push,
   output b64sc_pkg::job_type         push_job
);

   logic        dir_ff, dir_in;
   logic [1:0]  pos_ff, pos_in;
   logic [23:0] held_ff, held_in;
   logic        third_pad_ff, third_pad_in;

   logic        accept;
   logic [7:0]  b;
   logic        fin;
   logic        is_pad;
   logic [2:0]  n;
   logic [23:0] enc_held;
   logic [23:0] dec_held;
   logic [23:0] triple;

   assign req_stall = queue_full;
   assign accept    = req_valid && !req_stall;
   assign b         = req_payload.data_byte;
   assign fin       = req_payload.is_final;
   assign is_pad    = (b == b64sc_pkg::CHAR_PAD);
   assign n         = 3'({1'b0, pos_ff} + 3'd1);
   assign enc_held  = {held_ff[15:0], b};
   assign dec_held  = {held_ff[17:0], b64sc_pkg::sextet_of(b)};

   // Left-align a short encode group so missing bytes read as zero.
   always_comb begin
      case (pos_ff)
         2'd0:    triple = {b, 16'h0000};
         2'd1:    triple = {held_ff[7:0], b, 8'h00};
         default: triple = enc_held;
      endcase
   end

   // Group state update and job formation.
   always_comb begin
      dir_in       = dir_ff;
      pos_in       = pos_ff;
      held_in      = held_ff;
      third_pad_in = third_pad_ff;
      push         = 1'b0;
      push_job     = '{kind: b64sc_pkg::JOB_ENCODE, bits: triple, count: 3'd4,
                       chars: 3'(n + 3'd1), fin: fin};

      if (csr_wr_en) begin
         // A direction write drops any partial group.
         dir_in       = csr_wr_data;
         pos_in       = 2'd0;
         held_in      = 24'h0;
         third_pad_in = 1'b0;
      end else if (accept && !dir_ff) begin
         if (n == 3'd3 || fin) begin
            push         = 1'b1;
            pos_in       = 2'd0;
            held_in      = 24'h0;
            third_pad_in = 1'b0;
         end else begin
            pos_in  = n[1:0];
            held_in = enc_held;
         end
      end else if (accept) begin
         if (n == 3'd4) begin
            // Final group loses one byte per trailing pad character.
            push     = 1'b1;
            push_job = '{kind: b64sc_pkg::JOB_DECODE, bits: dec_held,
                         count: 3'(3'd3 - {2'b00, fin && is_pad}
                                   - {2'b00, fin && third_pad_ff}),
                         chars: 3'd0, fin: fin};
            pos_in       = 2'd0;
            held_in      = 24'h0;
            third_pad_in = 1'b0;
         end else if (fin) begin
            // Message ended inside a group: one error beat.
            push     = 1'b1;
            push_job = '{kind: b64sc_pkg::JOB_ERROR, bits: 24'h0, count: 3'd1,
                         chars: 3'd0, fin: 1'b1};
            pos_in       = 2'd0;
            held_in      = 24'h0;
            third_pad_in = 1'b0;
         end else begin
            pos_in  = n[1:0];
            held_in = dec_held;
            if (n == 3'd3) begin
               third_pad_in = is_pad;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dir_ff       <= 1'b0;
         pos_ff       <= 2'd0;
         held_ff      <= 24'h0;
         third_pad_ff <= 1'b0;
      end else begin
         dir_ff       <= dir_in;
         pos_ff       <= pos_in;
         held_ff      <= held_in;
         third_pad_ff <= third_pad_in;
      end
   end

endmodule

### rtl/b64sc_back.sv
// Codec back: walks each queued job, one result beat per cycle unless stalled,
// into an output register. Depends on b64sc_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "base64_stream_codec_core_macros.svh"

module b64sc_back (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       job_valid,
   input  b64sc_pkg::job_type         job,
   output logic                       pop,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output b64sc_pkg::rsp_payload_type rsp_payload
);

   logic [1:0]                 idx_ff, idx_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   b64sc_pkg::rsp_payload_type rsp_payload_ff, rsp_payload_in;

   logic       load;
   logic       last;
   logic [5:0] sextet;
   logic [7:0] dec_byte;

   assign load = job_valid && (!rsp_valid_ff || !rsp_stall);
   assign last = (3'({1'b0, idx_ff} + 3'd1) == job.count);
   assign pop  = load && last;

   // Pick the sextet and the byte for the current beat.
   always_comb begin
      case (idx_ff)
         2'd0: begin
            sextet   = job.bits[23:18];
            dec_byte = job.bits[23:16];
         end
         2'd1: begin
            sextet   = job.bits[17:12];
            dec_byte = job.bits[15:8];
         end
         2'd2: begin
            sextet   = job.bits[11:6];
            dec_byte = job.bits[7:0];
         end
         default: begin
            sextet   = job.bits[5:0];
            dec_byte = job.bits[7:0];
         end
      endcase
   end

   // Form the next result beat.
   always_comb begin
      unique case (job.kind)
         b64sc_pkg::JOB_ENCODE: begin
            rsp_payload_in.out_byte   = ({1'b0, idx_ff} < job.chars)
                                        ? b64sc_pkg::char_of(sextet)
                                        : b64sc_pkg::CHAR_PAD;
            rsp_payload_in.out_final  = last && job.fin;
            rsp_payload_in.bad_length = 1'b0;
         end
         b64sc_pkg::JOB_DECODE: begin
            rsp_payload_in.out_byte   = dec_byte;
            rsp_payload_in.out_final  = last && job.fin;
            rsp_payload_in.bad_length = 1'b0;
         end
         default: begin
            rsp_payload_in.out_byte   = 8'h00;
            rsp_payload_in.out_final  = 1'b1;
            rsp_payload_in.bad_length = 1'b1;
         end
      endcase
   end

   // Beat index within the job and output register hand-off.
   always_comb begin
      idx_in = idx_ff;
      if (load) begin
         idx_in = last ? 2'd0 : 2'(idx_ff + 2'd1);
      end
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   `B64SC_ASSERT_NOW(a_mid_job_held, idx_ff != 2'd0, job_valid, "job left mid-way")
   `B64SC_ASSERT_NOW(a_count_range, job_valid, job.count != 3'd0 && job.count <= 3'd4, "bad beat count")
   `B64SC_ASSERT_NOW(a_bad_is_final, rsp_valid_ff && rsp_payload_ff.bad_length, rsp_payload_ff.out_final, "error beat not final")

endmodule

### rtl/base64_stream_codec_core.sv
// Top level of the base64 stream codec: front, job queue and back.
// Depends on b64sc_pkg, b64sc_front, b64sc_queue and b64sc_back.
//
//   Channel  Handshake                 Payload
//   req      req_valid / req_stall     req_payload (data_byte, is_final)
//   rsp      rsp_valid / rsp_stall     rsp_payload (out_byte, out_final, bad_length)
//   csr      csr_wr_en                 csr_wr_data (direction)
//
// An input beat is taken whenever the two-entry job queue is not full.
// The back emits one result beat per cycle while rsp_stall is low, from its
// single output register; encode turns three input beats into four result
// beats and decode turns four input beats into up to three.
// Reset is synchronous and clears direction, group state, queue and output.
// A stalled result does not block input until the job queue fills.
`timescale 1ns / 1ps

module base64_stream_codec_core (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_wr_en,
   input  logic                       csr_wr_data,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  b64sc_pkg::req_payload_type req_payload,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output b64sc_pkg::rsp_payload_type rsp_payload
);

   logic               push;
   b64sc_pkg::job_type push_job;
   logic               queue_full;
   logic               job_valid;
   b64sc_pkg::job_type job;
   logic               pop;

   b64sc_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .queue_full  (queue_full),
      .push        (push),
      .push_job    (push_job)
   );

   b64sc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_job  (push_job),
      .full      (queue_full),
      .pop_valid (job_valid),
      .pop_job   (job),
      .pop       (pop)
   );

   b64sc_back u_back (
      .clock       (clock),
      .reset       (reset),
      .job_valid   (job_valid),
      .job         (job),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule
